// ===== sv/lcs_pkg.sv =====
// Shared types, codes and tables for the character LCD command sequencer.
package lcs_pkg;

    localparam int DESC_DEPTH_DEFAULT = 4;
    localparam int OUT_DEPTH_DEFAULT  = 2;

    localparam logic [2:0] MODE_COMMAND  = 3'd0;
    localparam logic [2:0] MODE_CHAR     = 3'd1;
    localparam logic [2:0] MODE_POSITION = 3'd2;
    localparam logic [2:0] MODE_NUMBER   = 3'd3;
    localparam logic [2:0] MODE_INIT     = 3'd4;

    localparam logic [1:0] LINE_ONE = 2'd1;
    localparam logic [1:0] LINE_TWO = 2'd2;

    localparam logic [7:0] DDRAM_LINE_ONE = 8'h80;
    localparam logic [7:0] DDRAM_LINE_TWO = 8'hC0;
    localparam logic [7:0] ASCII_ZERO     = 8'd48;
    localparam logic [7:0] RECIP_TEN      = 8'd205;   // 2^11 / 10, rounded up
    localparam logic [3:0] TEN            = 4'd10;

    localparam int WR_IDX_W = 3;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_NUMBER = 2'd1,
        KIND_INIT   = 2'd2
    } lcs_kind_t;

    typedef struct packed {
        lcs_kind_t  kind;
        logic       is_data;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
    } lcs_desc_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } lcs_write_t;

    localparam logic [WR_IDX_W-1:0] INIT_LAST_IDX = 3'd4;

    function automatic logic [7:0] init_byte(input logic [WR_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h38;   // 8-bit bus, two lines
            3'd1:    b = 8'h38;
            3'd2:    b = 8'h06;   // entry mode: increment
            3'd3:    b = 8'h0C;   // display on, cursor off
            3'd4:    b = 8'h01;   // clear display
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [WR_IDX_W-1:0] last_idx(input lcs_kind_t kind);
        logic [WR_IDX_W-1:0] n;
        case (kind)
            KIND_SINGLE: n = 3'd0;
            KIND_NUMBER: n = 3'd1;
            KIND_INIT:   n = INIT_LAST_IDX;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== sv/char_lcd_command_sequencer.sv =====
// Top level of the character LCD command sequencer: decoder, queues, write sequencer.
// Path: a request accepted at the input goes through the descriptor queue, then the write
// sequencer fills the result queue, whose head is on the result ports and can be popped.
// Throughput: one request per cycle while the descriptor queue has room; the sequencer
// issues one bus write per cycle while the result queue has room, 1 to 5 per request.
// Reset (rst_n low, asynchronous) empties both queues and rewinds the sequencer.
module char_lcd_command_sequencer
    import lcs_pkg::*;
#(
    parameter int DESC_DEPTH = DESC_DEPTH_DEFAULT,
    parameter int OUT_DEPTH  = OUT_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] mode,
    input  logic [7:0] value,
    input  logic [1:0] line,
    input  logic [5:0] column,
    output logic       empty,
    input  logic       pop,
    output logic       is_data,
    output logic [7:0] bus_byte,
    output logic       last
);

    localparam int DESC_W = $bits(lcs_desc_t);
    localparam int WR_W   = $bits(lcs_write_t);

    logic       has_writes;
    lcs_desc_t  front_desc;
    lcs_desc_t  head_desc;
    logic       desc_empty;
    logic       desc_pop;
    logic       wr_full;
    logic       wr_push;
    lcs_write_t back_wr;
    lcs_write_t out_wr;

    // Decode the request; requests that cause no write never enter the queue.
    lcs_front u_front (
        .mode       (mode),
        .value      (value),
        .line       (line),
        .column     (column),
        .has_writes (has_writes),
        .desc       (front_desc)
    );

    // Descriptor queue: lets the decoder keep taking beats while the
    // sequencer works through a long init run.
    lcs_fifo #(
        .WIDTH (DESC_W),
        .DEPTH (DESC_DEPTH)
    ) u_desc_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && has_writes),
        .push_data (front_desc),
        .full      (full),
        .pop       (desc_pop),
        .pop_data  (head_desc),
        .empty     (desc_empty)
    );

    // Advance through the writes of the head descriptor, one per cycle while the result queue has room.
    lcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_empty (desc_empty),
        .desc       (head_desc),
        .desc_pop   (desc_pop),
        .wr_full    (wr_full),
        .wr_push    (wr_push),
        .wr         (back_wr)
    );

    // Result queue: hold finished writes until the pin side pops them.
    lcs_fifo #(
        .WIDTH (WR_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (wr_push),
        .push_data (back_wr),
        .full      (wr_full),
        .pop       (pop),
        .pop_data  (out_wr),
        .empty     (empty)
    );

    assign is_data  = out_wr.is_data;
    assign bus_byte = out_wr.bus_byte;
    assign last     = out_wr.last;

endmodule

// ===== sv/lcs_fifo.sv =====
// Small synchronous queue with a combinational head read.
module lcs_fifo
    import lcs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/lcs_front.sv =====
// Request decoder: classifies a request and precomputes its write bytes.
module lcs_front
    import lcs_pkg::*;
(
    input  logic [2:0] mode,
    input  logic [7:0] value,
    input  logic [1:0] line,
    input  logic [5:0] column,
    output logic       has_writes,
    output lcs_desc_t  desc
);

    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  tens_x10;
    logic [7:0]  ones;

    // value / 10 by reciprocal, exact for all 8-bit values
    assign prod     = value * RECIP_TEN;
    assign tens     = prod[15:11];
    assign tens_x10 = {3'b000, tens} * {4'b0000, TEN};
    assign ones     = value - tens_x10;

    always_comb
    begin
        has_writes   = 1'b0;
        desc.kind    = KIND_SINGLE;
        desc.is_data = 1'b0;
        desc.byte_a  = value;
        desc.byte_b  = 8'h00;
        case (mode)
            MODE_COMMAND:
            begin
                has_writes = 1'b1;
            end
            MODE_CHAR:
            begin
                has_writes   = 1'b1;
                desc.is_data = 1'b1;
            end
            MODE_POSITION:
            begin
                if (line == LINE_ONE)
                begin
                    has_writes  = 1'b1;
                    desc.byte_a = DDRAM_LINE_ONE + {2'b00, column} - 8'd1;
                end
                else if (line == LINE_TWO)
                begin
                    has_writes  = 1'b1;
                    desc.byte_a = DDRAM_LINE_TWO + {2'b00, column} - 8'd1;
                end
            end
            MODE_NUMBER:
            begin
                has_writes   = 1'b1;
                desc.kind    = KIND_NUMBER;
                desc.is_data = 1'b1;
                desc.byte_a  = ASCII_ZERO + {3'b000, tens};
                desc.byte_b  = ASCII_ZERO + {4'b0000, ones[3:0]};
            end
            MODE_INIT:
            begin
                has_writes = 1'b1;
                desc.kind  = KIND_INIT;
            end
            default:
            begin
                has_writes = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/lcs_back.sv =====
// Write sequencer: expands one descriptor into its run of bus writes.
module lcs_back
    import lcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       desc_empty,
    input  lcs_desc_t  desc,
    output logic       desc_pop,
    input  logic       wr_full,
    output logic       wr_push,
    output lcs_write_t wr
);

    logic [WR_IDX_W-1:0] idx_reg, idx_next;
    logic                is_last;

    assign is_last  = (idx_reg == last_idx(desc.kind));
    assign wr_push  = !desc_empty && !wr_full;
    assign desc_pop = wr_push && is_last;

    always_comb
    begin
        wr.is_data = desc.is_data;
        wr.last    = is_last;
        case (desc.kind)
            KIND_SINGLE: wr.bus_byte = desc.byte_a;
            KIND_NUMBER: wr.bus_byte = (idx_reg == '0) ? desc.byte_a : desc.byte_b;
            KIND_INIT:   wr.bus_byte = init_byte(idx_reg);
            default:     wr.bus_byte = desc.byte_a;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (wr_push)
        begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule
